// File: hdl/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int SYM_W       = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W      = $clog2(2 * MAX_SYMBOLS - 1);
    localparam int WEIGHT_W    = 16;
    localparam int SUM_W       = 22;
    localparam int CODE_W      = 63;
    localparam int LEN_W       = 6;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    typedef struct packed {
        logic                vld;
        logic [SUM_W-1:0]    w;
        logic [NODE_W-1:0]   idx;
    } hcb_ent_t;

    typedef struct packed {
        logic                    clr;
        logic                    load;
        logic                    merge;
        logic [SUM_W+NODE_W-1:0] key;
    } hcb_qcmd_t;

    typedef struct packed {
        logic              merge;
        logic              shift;
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
        logic [NODE_W-1:0] nid;
    } hcb_lcmd_t;

    function automatic logic ent_lt(hcb_ent_t e, logic [SUM_W+NODE_W-1:0] key);
        ent_lt = e.vld && ({e.w, e.idx} < key);
    endfunction

endpackage

// File: hdl/huffman_code_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol weights, builds the Huffman tree, emits one code per symbol.
// ----------------------------------------------------------------------------
// Weights are taken one per cycle. The beat marked last_weight starts the
// build: a sorted queue of cells pops the two lightest roots and inserts their
// sum each cycle, so N symbols take N-1 merges. Codes then shift out of the
// leaf cell row, one beat per symbol. No weight is taken during build or
// output.
module huffman_code_builder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         weight_valid,
    output logic                         weight_stall,
    input  logic [hcb_pkg::WEIGHT_W-1:0] weight,
    input  logic                         last_weight,
    output logic                         code_valid,
    input  logic                         code_stall,
    output logic [hcb_pkg::SYM_W-1:0]    symbol,
    output logic [hcb_pkg::CODE_W-1:0]   code_bits,
    output logic [hcb_pkg::LEN_W-1:0]    code_length,
    output logic                         last_code
);
    import hcb_pkg::*;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  qcnt_reg, qcnt_next;
    logic [NODE_W-1:0] nid_reg, nid_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;

    logic              in_acc, out_acc, store;
    hcb_qcmd_t         qcmd;
    hcb_lcmd_t         lcmd;
    hcb_ent_t          q [MAX_SYMBOLS];
    hcb_ent_t          qx [MAX_SYMBOLS+2];
    hcb_ent_t          a_ent, b_ent, lo_ent, hi_ent;
    logic [SUM_W-1:0]  sum;
    logic [CODE_W-1:0] lcode [MAX_SYMBOLS+1];
    logic [LEN_W-1:0]  llen [MAX_SYMBOLS+1];

    assign weight_stall = state_reg != ST_LOAD;
    assign code_valid   = state_reg == ST_EMIT;
    assign in_acc       = weight_valid && !weight_stall;
    assign out_acc      = code_valid && !code_stall;
    assign store        = in_acc && (cnt_reg != CNT_W'(MAX_SYMBOLS));

    assign a_ent  = q[0];
    assign b_ent  = q[1];
    assign lo_ent = (a_ent.idx < b_ent.idx) ? a_ent : b_ent;
    assign hi_ent = (a_ent.idx < b_ent.idx) ? b_ent : a_ent;
    assign sum    = a_ent.w + b_ent.w;

    // the final root is dropped from the queue once its codes are out
    always_comb
    begin
        qcmd.clr   = out_acc && last_code;
        qcmd.load  = store;
        qcmd.merge = state_reg == ST_MERGE;
        if (state_reg == ST_MERGE)
            qcmd.key = {sum, nid_reg};
        else
            qcmd.key = {SUM_W'(weight), NODE_W'(cnt_reg)};
        lcmd.merge = state_reg == ST_MERGE;
        lcmd.shift = out_acc;
        lcmd.lo    = lo_ent.idx;
        lcmd.hi    = hi_ent.idx;
        lcmd.nid   = nid_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        qcnt_next  = qcnt_reg;
        nid_next   = nid_reg;
        sym_next   = sym_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (store)
                    cnt_next = cnt_reg + CNT_W'(1);
                if (in_acc && last_weight)
                begin
                    qcnt_next = cnt_next;
                    nid_next  = NODE_W'(cnt_next);
                    sym_next  = '0;
                    state_next = (cnt_next == CNT_W'(1)) ? ST_EMIT : ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                qcnt_next = qcnt_reg - CNT_W'(1);
                nid_next  = nid_reg + NODE_W'(1);
                if (qcnt_reg == CNT_W'(2))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    sym_next = sym_reg + SYM_W'(1);
                    if (last_code)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            qcnt_reg  <= '0;
            nid_reg   <= '0;
            sym_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            qcnt_reg  <= qcnt_next;
            nid_reg   <= nid_next;
            sym_reg   <= sym_next;
        end
    end

    assign qx[0].vld = 1'b0;
    assign qx[0].w   = '0;
    assign qx[0].idx = '0;
    assign qx[MAX_SYMBOLS+1] = qx[0];
    assign lcode[MAX_SYMBOLS] = '0;
    assign llen[MAX_SYMBOLS]  = '0;

    genvar i;
    generate
        for (i = 0; i < MAX_SYMBOLS; i++)
        begin : g_cell
            assign qx[i+1] = q[i];
            hcb_queue_cell u_q (
                .clk   (clk),
                .rst_n (rst_n),
                .head  (i == 0),
                .cmd   (qcmd),
                .prev1 (qx[i]),
                .next1 (qx[i+2]),
                .next2 ((i + 2 < MAX_SYMBOLS) ? q[(i+2) % MAX_SYMBOLS] : qx[0]),
                .ent   (q[i])
            );
            hcb_leaf_cell u_l (
                .clk       (clk),
                .rst_n     (rst_n),
                .ld        (store && (cnt_reg == CNT_W'(i))),
                .id        (NODE_W'(i)),
                .cmd       (lcmd),
                .next_code (lcode[i+1]),
                .next_len  (llen[i+1]),
                .code      (lcode[i]),
                .len       (llen[i])
            );
        end
    endgenerate

    assign symbol      = sym_reg;
    assign code_bits   = lcode[0];
    assign code_length = llen[0];
    assign last_code   = (CNT_W'(sym_reg) + CNT_W'(1)) == cnt_reg;

endmodule

// File: hdl/hcb_queue_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_queue_cell
// One slot of the sorted root queue; ordered by weight, then node index.
// ----------------------------------------------------------------------------
module hcb_queue_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head,
    input  hcb_pkg::hcb_qcmd_t cmd,
    input  hcb_pkg::hcb_ent_t  prev1,
    input  hcb_pkg::hcb_ent_t  next1,
    input  hcb_pkg::hcb_ent_t  next2,
    output hcb_pkg::hcb_ent_t  ent
);
    import hcb_pkg::*;

    hcb_ent_t ent_reg;
    hcb_ent_t ent_next;
    hcb_ent_t own;
    hcb_ent_t prv;
    hcb_ent_t kent;

    always_comb
    begin
        own  = cmd.merge ? next2 : ent_reg;
        prv  = cmd.merge ? next1 : prev1;
        kent.vld = 1'b1;
        kent.w   = cmd.key[SUM_W+NODE_W-1:NODE_W];
        kent.idx = cmd.key[NODE_W-1:0];
        ent_next = ent_reg;
        if (cmd.clr)
            ent_next.vld = 1'b0;
        else if (cmd.load || cmd.merge)
        begin
            if (ent_lt(own, cmd.key))
                ent_next = own;
            else if (head || ent_lt(prv, cmd.key))
                ent_next = kent;
            else
                ent_next = prv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.vld <= 1'b0;
            ent_reg.w   <= '0;
            ent_reg.idx <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

// File: hdl/hcb_leaf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_leaf_cell
// Per-symbol code register; tracks the symbol's current root during build.
// ----------------------------------------------------------------------------
module hcb_leaf_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         ld,
    input  logic [hcb_pkg::NODE_W-1:0]   id,
    input  hcb_pkg::hcb_lcmd_t           cmd,
    input  logic [hcb_pkg::CODE_W-1:0]   next_code,
    input  logic [hcb_pkg::LEN_W-1:0]    next_len,
    output logic [hcb_pkg::CODE_W-1:0]   code,
    output logic [hcb_pkg::LEN_W-1:0]    len
);
    import hcb_pkg::*;

    logic [NODE_W-1:0] root_reg, root_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              grow;

    always_comb
    begin
        root_next = root_reg;
        code_next = code_reg;
        len_next  = len_reg;
        grow      = len_reg != LEN_W'(CODE_W);
        if (ld)
        begin
            root_next = id;
            code_next = '0;
            len_next  = '0;
        end
        else if (cmd.shift)
        begin
            code_next = next_code;
            len_next  = next_len;
        end
        else if (cmd.merge && (root_reg == cmd.lo || root_reg == cmd.hi))
        begin
            root_next = cmd.nid;
            if (grow)
            begin
                if (root_reg == cmd.hi)
                    code_next = code_reg | (CODE_W'(1) << len_reg);
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            code_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            root_reg <= root_next;
            code_reg <= code_next;
            len_reg  <= len_next;
        end
    end

    assign code = code_reg;
    assign len  = len_reg;

endmodule

// File: hdl/hcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks of the Huffman code builder.
// ----------------------------------------------------------------------------
module hcb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         weight_valid,
    input logic                         weight_stall,
    input logic                         code_valid,
    input logic                         code_stall,
    input logic [hcb_pkg::SYM_W-1:0]    symbol,
    input logic [hcb_pkg::CODE_W-1:0]   code_bits,
    input logic [hcb_pkg::LEN_W-1:0]    code_length,
    input logic                         last_code
);
    import hcb_pkg::*;

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && weight_valid |-> weight_stall)
        else $error("weight taken while codes pending");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_stall && !last_code |=> code_valid)
        else $error("code burst broken");

    a_symbol_step: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_stall && !last_code |=>
            symbol == $past(symbol) + SYM_W'(1))
        else $error("symbol order wrong");

    a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (code_bits >> code_length) == '0)
        else $error("bits above code length");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .symbol       (symbol),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .last_code    (last_code)
);
